@@ rtl/pipe_name_matcher_core_macros.svh @@
// Assertion macros for the pipe name matcher.
`ifndef PIPE_NAME_MATCHER_CORE_MACROS_SVH
`define PIPE_NAME_MATCHER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// when a holds, b holds in the same cycle
`define PNM_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("pipe name matcher check failed");
// when a holds, b holds in the next cycle
`define PNM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("pipe name matcher check failed");
`else
`define PNM_ASSERT_NOW(label, clk, rst_n, a, b)
`define PNM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/pnm_pkg.sv @@
package pnm_pkg;

    localparam int NUM_ENTRIES = 35;
    localparam logic [5:0] ST_FAIL = 6'd35;
    localparam logic [5:0] ST_DONE = 6'd36;

    // match table: expected character, next entry on match, entry on mismatch
    localparam logic [7:0] TBL_CHAR [NUM_ENTRIES] = '{
        8'h5C, 8'h50, 8'h49, 8'h50, 8'h45, 8'h5C, 8'h00, 8'h00,   // \PIPE\ nul nul
        8'h57, 8'h4B, 8'h53, 8'h53, 8'h56, 8'h43,                 // WKSSVC
        8'h49, 8'h4E, 8'h52, 8'h45, 8'h47,                        // INREG
        8'h53, 8'h52, 8'h56, 8'h53, 8'h56, 8'h43,                 // SRVSVC
        8'h41, 8'h4D, 8'h52,                                      // AMR
        8'h4C, 8'h53, 8'h41, 8'h52, 8'h50, 8'h43,                 // LSARPC
        8'h00
    };
    localparam logic [5:0] TBL_NEXT [NUM_ENTRIES] = '{
        6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, ST_DONE, ST_DONE,
        6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd34,
        6'd15, 6'd16, 6'd17, 6'd18, 6'd34,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd34,
        6'd26, 6'd27, 6'd34,
        6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34,
        ST_DONE
    };
    localparam logic [5:0] TBL_FAIL [NUM_ENTRIES] = '{
        ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, 6'd7, 6'd8, ST_FAIL,
        6'd19, 6'd14, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL,
        ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL,
        6'd28, 6'd25, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL,
        ST_FAIL, ST_FAIL, ST_FAIL,
        ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL, ST_FAIL,
        ST_FAIL
    };

    typedef struct packed {
        logic capture;  // latch the request
        logic start;    // apply a new-name request
        logic step;     // pad / high byte handling
        logic walk;     // one table entry per cycle
        logic check;    // end-of-character checks
    } t_cmd;

    typedef struct packed {
        logic decided;
        logic emit;       // zero-length verdict pending
        logic pad;
        logic high;
        logic high_bad;   // high byte not zero
        logic wide;
        logic walk_oob;   // walk hit the fail state
        logic walk_hit;
        logic check_hit;  // check gives a verdict
        logic match_done;
    } t_status;

endpackage

@@ rtl/pnm_dpath.sv @@
module pnm_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pnm_pkg::t_cmd    i_cmd,
    input  logic [39:0]      i_tdata,
    input  logic [1:0]       i_tuser,
    output pnm_pkg::t_status o_status,
    output logic             o_verdict
);
    import pnm_pkg::*;

    logic [7:0]  r_byte;
    logic        r_first;
    logic        r_uni;
    logic [15:0] r_plen;
    logic [15:0] r_bc;
    logic [5:0]  r_match, n_match;
    logic [15:0] r_left, n_left;
    logic        r_wide, n_wide;
    logic        r_pad, n_pad;
    logic        r_high, n_high;
    logic [5:0]  r_pend, n_pend;
    logic        r_decided, n_decided;
    logic        r_emit, n_emit;
    logic        r_verdict, n_verdict;

    logic [7:0]  upper;
    logic        idx_ok;
    logic [7:0]  ent_char;
    logic [5:0]  ent_next;
    logic [5:0]  ent_fail;
    logic        short_len;

    assign upper    = (r_byte >= 8'h61 && r_byte <= 8'h7A) ? r_byte - 8'd32 : r_byte;
    assign idx_ok   = r_match < ST_FAIL;
    assign ent_char = idx_ok ? TBL_CHAR[r_match] : 8'h00;
    assign ent_next = idx_ok ? TBL_NEXT[r_match] : ST_FAIL;
    assign ent_fail = idx_ok ? TBL_FAIL[r_match] : ST_FAIL;
    // fewer bytes left than one character needs
    assign short_len = (r_left[15:1] == 15'd0) && (r_wide || !r_left[0]);

    always_comb begin
        o_status.decided    = r_decided;
        o_status.emit       = r_emit;
        o_status.pad        = r_pad;
        o_status.high       = r_high;
        o_status.high_bad   = r_byte != 8'h00;
        o_status.wide       = r_wide;
        o_status.walk_oob   = !idx_ok;
        o_status.walk_hit   = idx_ok && (ent_char == upper);
        o_status.check_hit  = (r_match == ST_DONE) || (r_match >= ST_FAIL) || short_len;
        o_status.match_done = r_match == ST_DONE;
    end

    assign o_verdict = r_verdict;

    always_comb begin
        n_match   = r_match;
        n_left    = r_left;
        n_wide    = r_wide;
        n_pad     = r_pad;
        n_high    = r_high;
        n_pend    = r_pend;
        n_decided = r_decided;
        n_emit    = r_emit;
        n_verdict = r_verdict;
        if (i_cmd.capture) begin
            n_emit = 1'b0;
        end
        if (i_cmd.start && r_first) begin
            n_decided = 1'b0;
            n_match   = 6'd0;
            n_pend    = 6'd0;
            n_high    = 1'b0;
            n_wide    = r_uni;
            n_pad     = r_uni;
            if (r_plen == 16'd0 || r_bc == 16'd0) begin
                n_left    = 16'd0;
                n_decided = 1'b1;
                n_emit    = 1'b1;
                n_verdict = 1'b0;
            end else begin
                n_left = (r_bc < r_plen) ? r_bc : r_plen;
            end
        end
        if (i_cmd.step) begin
            if (r_pad) begin
                n_pad  = 1'b0;
                n_left = r_left - 16'd1;
            end else if (r_high) begin
                n_high = 1'b0;
                if (r_byte != 8'h00) begin
                    n_decided = 1'b1;
                    n_verdict = 1'b0;
                end else begin
                    n_match = r_pend;
                    n_left  = r_left - 16'd2;
                end
            end
        end
        if (i_cmd.walk) begin
            if (!idx_ok) begin
                n_match   = ST_FAIL;
                n_decided = 1'b1;
                n_verdict = 1'b0;
            end else if (ent_char == upper) begin
                if (r_wide) begin
                    n_pend = ent_next;
                    n_high = 1'b1;
                end else begin
                    n_match = ent_next;
                    n_left  = r_left - 16'd1;
                end
            end else begin
                n_match = ent_fail;
            end
        end
        if (i_cmd.check && o_status.check_hit) begin
            n_decided = 1'b1;
            n_verdict = r_match == ST_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte  <= i_tdata[7:0];
            r_plen  <= i_tdata[23:8];
            r_bc    <= i_tdata[39:24];
            r_first <= i_tuser[0];
            r_uni   <= i_tuser[1];
        end
        r_verdict <= n_verdict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match   <= 6'd0;
            r_left    <= 16'd0;
            r_wide    <= 1'b0;
            r_pad     <= 1'b0;
            r_high    <= 1'b0;
            r_pend    <= 6'd0;
            r_decided <= 1'b1;
            r_emit    <= 1'b0;
        end else begin
            r_match   <= n_match;
            r_left    <= n_left;
            r_wide    <= n_wide;
            r_pad     <= n_pad;
            r_high    <= n_high;
            r_pend    <= n_pend;
            r_decided <= n_decided;
            r_emit    <= n_emit;
        end
    end

endmodule

@@ rtl/pnm_ctrl.sv @@
module pnm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  pnm_pkg::t_status i_status,
    output pnm_pkg::t_cmd    o_cmd
);
    import pnm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_STEP  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_STEP;
            end
            S_STEP: begin
                o_cmd.step = !i_status.decided;
                if (i_status.decided) begin
                    n_state = i_status.emit ? S_OUT : S_IDLE;
                end else if (i_status.pad) begin
                    n_state = S_CHECK;
                end else if (i_status.high) begin
                    n_state = i_status.high_bad ? S_OUT : S_CHECK;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.walk_oob) begin
                    n_state = S_OUT;
                end else if (i_status.walk_hit) begin
                    n_state = i_status.wide ? S_IDLE : S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.check_hit ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/pipe_name_matcher_core.sv @@
// Channel   Direction  Ports            Contents
// s_axis    in         tdata[39:0]      name byte, pdu length, byte count
//                      tuser[1:0]       first, unicode
// m_axis    out        tdata[7:0]       verdict (1 = pipe name accepted)
//
// Requests: one at a time; a new one is taken only once the last is through.
// Idle requests, pad bytes and high bytes need no table walk; a wide low byte
// or an ASCII character walks the fail links, one table entry per cycle, and
// a verdict, when one is due, is handed out on m_axis before the next request.
// Reset: synchronous, active low; the matcher is idle until a first request.
// Stalls: the input is not taken while a verdict waits on m_axis.
`include "pipe_name_matcher_core_macros.svh"

module pipe_name_matcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [7:0] name_byte, [23:8] pdu_len,
                                          // [39:24] byte_count
    input  logic [1:0]  i_s_axis_tuser,   // [0] first, [1] unicode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [0] name_valid, [7:1] zero
);
    import pnm_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    verdict;

    // sequencer: accept, apply new-name request, step, walk, check, hand out
    pnm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // match state, length bookkeeping and the constant table
    pnm_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .o_status (status),
        .o_verdict(verdict)
    );

    assign o_m_axis_tdata = {7'd0, verdict};

    // a pending verdict blocks new requests
    `PNM_ASSERT_NOW(a_out_blocks_in, i_clk, i_rst_n, o_m_axis_tvalid, !o_s_axis_tready)
    // an accepted verdict of 1 only comes from the done entry
    `PNM_ASSERT_NOW(a_accept_done, i_clk, i_rst_n, o_m_axis_tvalid && verdict, status.match_done)
    // an accepted request keeps the block busy next cycle
    `PNM_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

@@ test/tb_pipe_name_matcher_core.sv @@
module tb_pipe_name_matcher_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Match table positions past the last entry
    localparam int         TABLE_LEN = 35;
    localparam logic [5:0] POS_FAIL  = 6'd35;
    localparam logic [5:0] POS_DONE  = 6'd36;

    // Longest quiet spell allowed on both channels. A request is handled one at
    // a time with its verdict, the input is held off while a verdict waits, and
    // the random gaps and stalls between requests and verdicts add to the quiet.
    localparam int STALL_LIMIT     = 1000;
    localparam int SETTLE_CYCLES   = 24;
    localparam int RANDOM_REQUESTS = 1500;

    // Expected character, next position on a hit, position on a miss
    localparam logic [7:0] ENTRY_CHAR [TABLE_LEN] = '{
        8'h5C, 8'h50, 8'h49, 8'h50, 8'h45, 8'h5C, 8'h00, 8'h00,  // \PIPE\ nul nul
        8'h57, 8'h4B, 8'h53, 8'h53, 8'h56, 8'h43,                // WKSSVC
        8'h49, 8'h4E, 8'h52, 8'h45, 8'h47,                       // INREG
        8'h53, 8'h52, 8'h56, 8'h53, 8'h56, 8'h43,                // SRVSVC
        8'h41, 8'h4D, 8'h52,                                     // AMR
        8'h4C, 8'h53, 8'h41, 8'h52, 8'h50, 8'h43,                // LSARPC
        8'h00
    };
    localparam logic [5:0] ENTRY_HIT [TABLE_LEN] = '{
        6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, POS_DONE, POS_DONE,
        6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd34,
        6'd15, 6'd16, 6'd17, 6'd18, 6'd34,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd34,
        6'd26, 6'd27, 6'd34,
        6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34,
        POS_DONE
    };
    // note the R after S falls back to the A of SAMR
    localparam logic [5:0] ENTRY_MISS [TABLE_LEN] = '{
        POS_FAIL, POS_FAIL, POS_FAIL, POS_FAIL, POS_FAIL, 6'd7, 6'd8, POS_FAIL,
        6'd19, 6'd14, POS_FAIL, POS_FAIL, POS_FAIL, POS_FAIL,
        POS_FAIL, POS_FAIL, POS_FAIL, POS_FAIL, POS_FAIL,
        6'd28, 6'd25, POS_FAIL, POS_FAIL, POS_FAIL, POS_FAIL,
        POS_FAIL, POS_FAIL, POS_FAIL,
        POS_FAIL, POS_FAIL, POS_FAIL, POS_FAIL, POS_FAIL, POS_FAIL,
        POS_FAIL
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;   // [7:0] name byte, [23:8] pdu length,
                                        // [39:24] byte count
    logic [1:0]  i_s_axis_tuser = '0;   // [0] first, [1] unicode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;        // [0] name valid, [7:1] zero

    pipe_name_matcher_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Matcher state as predicted
    logic [5:0]  match_pos = '0;
    logic [15:0] bytes_left = '0;
    logic        wide_chars = 1'b0;
    logic        pad_due = 1'b0;
    logic        high_due = 1'b0;
    logic [5:0]  pos_after_high = '0;
    logic        name_open = 1'b0;      // no verdict given yet for the current name

    logic        verdict_q [$];         // verdicts still to come, oldest first
    logic [7:0]  name_bytes [$];        // request bytes of the name being built
    logic        want_verdict;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int requests_sent = 0;
    int names_sent = 0;
    int verdicts_seen = 0;
    int names_accepted = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // Candidate names; the tail ones are near misses
    string pipe_names [10] = '{
        "\\PIPE\\", "\\PIPE\\WKSSVC", "\\PIPE\\WINREG", "\\PIPE\\SRVSVC",
        "\\PIPE\\SAMR", "\\PIPE\\LSARPC", "\\PIPE", "\\",
        "\\PIPE\\SRVSV", "\\PIPE\\SAMRX"
    };

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: random stalls on the verdict channel
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic void post_verdict(logic v);
        verdict_q.push_back(v);
        name_open = 1'b0;
    endfunction

    // One accepted request moves the predicted matcher on
    function automatic void advance_name_match(logic [7:0] nb, logic first,
                                               logic [15:0] plen, logic [15:0] bc,
                                               logic uni);
        logic [7:0]  ch;
        logic [15:0] need;
        logic        hit;
        int          guard;
        if (first) begin
            name_open = 1'b1;
            match_pos = '0;
            pos_after_high = '0;
            high_due = 1'b0;
            wide_chars = uni;
            pad_due = uni;
            if (plen == 16'd0 || bc == 16'd0) begin
                bytes_left = '0;
                post_verdict(1'b0);
                return;
            end
            bytes_left = (bc < plen) ? bc : plen;
        end
        if (!name_open)
            return;

        need = wide_chars ? 16'd2 : 16'd1;

        if (pad_due) begin
            pad_due = 1'b0;
            bytes_left = bytes_left - 16'd1;
            if (bytes_left < need)
                post_verdict(1'b0);
            return;
        end

        if (high_due) begin
            high_due = 1'b0;
            if (nb != 8'h00) begin
                post_verdict(1'b0);
                return;
            end
            match_pos = pos_after_high;
            bytes_left = bytes_left - 16'd2;
        end else begin
            // case folding: lower-case letters only
            ch = (nb >= 8'h61 && nb <= 8'h7A) ? nb - 8'd32 : nb;
            hit = 1'b0;
            guard = 0;
            // follow miss links without consuming the character
            while (!hit && match_pos < TABLE_LEN && guard < 64) begin
                if (ENTRY_CHAR[match_pos] == ch)
                    hit = 1'b1;
                else
                    match_pos = ENTRY_MISS[match_pos];
                guard++;
            end
            if (!hit) begin
                match_pos = POS_FAIL;
                post_verdict(1'b0);
                return;
            end
            if (wide_chars) begin
                pos_after_high = ENTRY_HIT[match_pos];
                high_due = 1'b1;
                return;
            end
            match_pos = ENTRY_HIT[match_pos];
            bytes_left = bytes_left - 16'd1;
        end

        if (match_pos == POS_DONE)
            post_verdict(1'b1);
        else if (match_pos >= POS_FAIL)
            post_verdict(1'b0);
        else if (bytes_left < need)
            post_verdict(1'b0);
    endfunction

    // Drive one request and hold it until taken. tvalid stays high between
    // back-to-back requests and is only dropped for a gap.
    task automatic send_request(logic [7:0] nb, logic first, logic [15:0] plen,
                                logic [15:0] bc, logic uni);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tdata  <= {bc, plen, nb};
        i_s_axis_tuser  <= {uni, first};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        requests_sent++;
        advance_name_match(nb, first, plen, bc, uni);
    endtask

    // Continuation byte; the length fields and mode are ignored, so randomise them
    task automatic send_follow(logic [7:0] nb);
        send_request(nb, 1'b0, 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // Fill name_bytes with txt plus its closing nul, letters in random case.
    // Wide mode: pad byte first, then low/high pairs.
    function automatic void build_name(string txt, logic uni, int garble_pct);
        logic [7:0] ch;
        name_bytes.delete();
        if (uni)
            name_bytes.push_back(8'($urandom));
        for (int k = 0; k <= txt.len(); k++) begin
            ch = (k < txt.len()) ? txt[k] : 8'h00;
            if (((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A))
                && $urandom_range(1) == 1)
                ch = ch ^ 8'h20;
            if ($urandom_range(99) < garble_pct)
                ch = 8'($urandom);
            name_bytes.push_back(ch);
            if (uni)
                name_bytes.push_back(($urandom_range(99) < garble_pct / 2) ?
                                     8'($urandom_range(1, 255)) : 8'h00);
        end
    endfunction

    // Send the first upto bytes of name_bytes, stopping once decided
    task automatic send_name(logic [15:0] plen, logic [15:0] bc, logic uni, int upto);
        send_request(name_bytes[0], 1'b1, plen, bc, uni);
        names_sent++;
        for (int k = 1; k < upto && name_open; k++)
            send_follow(name_bytes[k]);
    endtask

    task automatic send_text(string txt, logic uni, logic [15:0] plen, logic [15:0] bc);
        build_name(txt, uni, 0);
        send_name(plen, bc, uni, name_bytes.size());
    endtask

    task automatic set_traffic(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Nothing has started yet, so these give no verdict
    task automatic test_idle_after_reset();
        send_follow(8'h5C);
        send_follow(8'hFF);
    endtask

    task automatic test_accepted_names();
        send_text("\\PIPE\\", 1'b0, 16'd7, 16'd7);
        send_text("\\PIPE\\WKSSVC", 1'b1, 16'hFFFF, 16'hFFFF);   // plenty of length
        send_text("\\PIPE\\WINREG", 1'b0, 16'd40, 16'd13);
        send_text("\\PIPE\\SRVSVC", 1'b1, 16'd27, 16'd200);
        send_text("\\PIPE\\SAMR", 1'b0, 16'd11, 16'd11);         // R after S falls back
        send_text("\\PIPE\\LSARPC", 1'b1, 16'd27, 16'd27);
        send_text("\\PIPE", 1'b0, 16'd6, 16'd6);
        send_text("\\", 1'b1, 16'd5, 16'd5);
        send_text("\\PIPE\\SAMRX", 1'b0, 16'd20, 16'd20);
        // idle requests once the verdict is out
        send_follow(8'h00);
        send_follow(8'hFF);
    endtask

    task automatic test_length_limits();
        send_text("\\PIPE\\", 1'b0, 16'd0, 16'hFFFF);
        send_text("\\PIPE\\", 1'b1, 16'hFFFF, 16'd0);
        send_text("\\PIPE\\SAMR", 1'b0, 16'd5, 16'd9);            // runs out mid-name
        send_text("\\PIPE\\", 1'b1, 16'd1, 16'd3);                // nothing left after pad
        send_text("\\PIPE\\", 1'b1, 16'd2, 16'd2);                // one byte after pad
        send_text("\\PIPE\\", 1'b1, 16'd4, 16'd4);                // odd byte left
        send_request(8'hFF, 1'b1, 16'd10, 16'd10, 1'b0);
        send_request(8'h80, 1'b1, 16'd10, 16'd10, 1'b0);
    endtask

    task automatic test_wide_high_byte();
        build_name("\\PIPE\\SRVSVC", 1'b1, 0);
        name_bytes[4] = 8'h01;                                    // high byte of P
        send_name(16'd27, 16'd27, 1'b1, name_bytes.size());
        build_name("\\PIPE\\LSARPC", 1'b1, 0);
        name_bytes[name_bytes.size() - 1] = 8'h80;                // high byte of the nul
        send_name(16'd27, 16'd27, 1'b1, name_bytes.size());
    endtask

    // A new first drops the unfinished name without a verdict
    task automatic test_restart();
        build_name("\\PIPE\\WKSSVC", 1'b0, 0);
        send_name(16'd13, 16'd13, 1'b0, 6);
        send_text("\\PIPE\\LSARPC", 1'b1, 16'd27, 16'd27);
        build_name("\\PIPE\\WINREG", 1'b1, 0);
        send_name(16'd27, 16'd27, 1'b1, 4);                       // stops before a high byte
        send_text("\\PIPE\\WINREG", 1'b0, 16'd13, 16'd13);
    endtask

    // Mostly well-formed names with random case, mode and lengths; some
    // garbled, cut short or followed by idle bytes, plus plain noise.
    task automatic test_random_traffic(int quota);
        int          stop_at;
        int          roll;
        int          usable;
        int          spare;
        int          upto;
        logic        uni;
        logic [15:0] plen;
        logic [15:0] bc;
        stop_at = requests_sent + quota;
        while (requests_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                send_request(8'($urandom), ($urandom_range(99) < 30), 16'($urandom),
                             16'($urandom), 1'($urandom));
            end else begin
                uni = 1'($urandom);
                build_name(pipe_names[$urandom_range(9)], uni,
                           ($urandom_range(3) == 0) ? 8 : 0);
                roll = $urandom_range(99);
                if (roll < 4) begin
                    plen = 16'($urandom);
                    bc = 16'($urandom);
                    if (roll < 2)
                        plen = '0;
                    else
                        bc = '0;
                end else if (roll < 85) begin
                    if (roll < 70)
                        usable = name_bytes.size() + $urandom_range(0, 3);
                    else
                        usable = $urandom_range(1, name_bytes.size());
                    spare = usable + $urandom_range(0, 65535 - usable);
                    if ($urandom_range(1) == 1) begin
                        plen = 16'(usable);
                        bc = 16'(spare);
                    end else begin
                        plen = 16'(spare);
                        bc = 16'(usable);
                    end
                end else begin
                    plen = 16'($urandom);
                    bc = 16'($urandom);
                end
                upto = ($urandom_range(99) < 5) ? $urandom_range(1, name_bytes.size())
                                                : name_bytes.size();
                send_name(plen, bc, uni, upto);
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(1, 3)) send_follow(8'($urandom));
            end
        end
    endtask

    // Verdict checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("verdict %02h with no name pending",
                                          o_m_axis_tdata));
            end else begin
                want_verdict = verdict_q.pop_front();
                verdicts_seen++;
                if (want_verdict)
                    names_accepted++;
                if (o_m_axis_tdata !== {7'd0, want_verdict})
                    report_mismatch($sformatf("verdict %02h, expected %02h",
                                              o_m_axis_tdata, {7'd0, want_verdict}));
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_accepted_names();
        test_length_limits();
        test_wide_high_byte();
        test_restart();

        set_traffic(0, 0);
        test_random_traffic(RANDOM_REQUESTS / 4);
        set_traffic(45, 0);
        test_random_traffic(RANDOM_REQUESTS / 4);
        set_traffic(0, 45);
        test_random_traffic(RANDOM_REQUESTS / 4);
        set_traffic(25, 25);
        test_random_traffic(RANDOM_REQUESTS / 4);

        i_s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests over %0d names, ascii and wide, under four traffic mixes",
                 requests_sent, names_sent);
        $display("%0d verdicts checked, %0d names accepted, %0d mismatches",
                 verdicts_seen, names_accepted, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
